/* sv/htfl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package htfl_pkg;

	// request opcodes
	localparam logic OP_CREATE  = 1'b0;
	localparam logic OP_DESTROY = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		STS_OK         = 2'd0,
		STS_BAD_PARAM  = 2'd1,
		STS_BAD_HANDLE = 2'd2,
		STS_FULL       = 2'd3
	} status_t;

	// request sequencer
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// fixed field widths
	localparam int OBJ_W   = 64;
	localparam int ACC_W   = 32;
	localparam int HND_W   = 32;
	localparam int LIVE_W  = 9;
	localparam int ENTRY_W = OBJ_W + ACC_W;

endpackage

`default_nettype wire

/* sv/handle_table_free_list_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------------
// request  | req_valid/req_ready  | opcode, object_ref, access_mask, handle_in
// response | rsp_valid/rsp_ready  | status, handle_out, released_ref, live_count
//
// a request is taken in ST_IDLE, where the slot entry and its next-free link are read
// synchronously; in ST_EXEC it is checked, written back and the free head updated.
// a new request is taken only after the last one leaves ST_EXEC; the response register
// holds one finished beat, and ST_EXEC waits while it is still full and not taken.
// no memory clearing after reset: a fill mark tracks the lowest slot never handed out,
// and slots at or above it read as free, with their link pointing at the next slot.

module handle_table_free_list_top #(
	parameter int TABLE_ENTRIES = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output logic                                 req_ready,
	input  wire logic                            opcode,
	input  wire logic [htfl_pkg::OBJ_W-1:0]      object_ref,
	input  wire logic [htfl_pkg::ACC_W-1:0]      access_mask,
	input  wire logic [htfl_pkg::HND_W-1:0]      handle_in,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_ready,
	output logic [1:0]                           status,
	output logic [htfl_pkg::HND_W-1:0]           handle_out,
	output logic [htfl_pkg::OBJ_W-1:0]           released_ref,
	output logic [htfl_pkg::LIVE_W-1:0]          live_count
);

	localparam int IDX_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int RAW_IDX_W = htfl_pkg::HND_W - 2;
	localparam logic [RAW_IDX_W-1:0] IDX_LIMIT = RAW_IDX_W'(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// table storage
	logic [htfl_pkg::ENTRY_W-1:0] ent_mem [TABLE_ENTRIES];
	logic [IDX_W-1:0]             nxt_mem [TABLE_ENTRIES];

	htfl_pkg::state_t state_q, state_d;

	logic [IDX_W-1:0]              head_q;
	logic [IDX_W:0]                fill_q;
	logic [htfl_pkg::LIVE_W-1:0]   live_q;

	// request stage
	logic                          op_s1;
	logic [htfl_pkg::OBJ_W-1:0]    obj_s1;
	logic [htfl_pkg::ACC_W-1:0]    acc_s1;
	logic [IDX_W-1:0]              addr_s1;
	logic                          err_s1;
	htfl_pkg::status_t             err_code_s1;
	logic [htfl_pkg::ENTRY_W-1:0]  ent_rd_s1;
	logic [IDX_W-1:0]              nxt_rd_s1;

	// response register
	logic                          rsp_valid_q;
	htfl_pkg::status_t             status_q;
	logic [htfl_pkg::HND_W-1:0]    handle_q;
	logic [htfl_pkg::OBJ_W-1:0]    released_q;
	logic [htfl_pkg::LIVE_W-1:0]   live_out_q;

	logic                          req_fire;
	logic                          exec_go;
	logic [RAW_IDX_W-1:0]          raw_idx;
	logic [IDX_W-1:0]              rd_addr;
	logic                          pre_err;
	htfl_pkg::status_t             pre_code;

	logic                          in_fill;
	logic [htfl_pkg::OBJ_W-1:0]    obj_cur;
	logic [IDX_W-1:0]              nxt_cur;
	logic                          ok;
	htfl_pkg::status_t             res_status;
	logic                          ent_we;
	logic                          nxt_we;
	logic [htfl_pkg::ENTRY_W-1:0]  ent_wdata;

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htfl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		exec_go   = 1'b0;
		unique case (state_q)
			htfl_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = htfl_pkg::ST_EXEC;
				end
			end
			htfl_pkg::ST_EXEC: begin
				if (!rsp_valid_q || rsp_ready) begin
					exec_go = 1'b1;
					state_d = htfl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = htfl_pkg::ST_IDLE;
			end
		endcase
	end

	assign req_fire = req_valid && req_ready;

	// request decode and early checks
	always_comb begin
		raw_idx  = handle_in[htfl_pkg::HND_W-1:2];
		pre_err  = 1'b0;
		pre_code = htfl_pkg::STS_OK;
		if (opcode == htfl_pkg::OP_CREATE) begin
			rd_addr = head_q;
			if (object_ref == '0) begin
				pre_err  = 1'b1;
				pre_code = htfl_pkg::STS_BAD_PARAM;
			end else if (head_q == '0) begin
				pre_err  = 1'b1;
				pre_code = htfl_pkg::STS_FULL;
			end
		end else begin
			rd_addr = raw_idx[IDX_W-1:0];
			if (handle_in == '0) begin
				pre_err  = 1'b1;
				pre_code = htfl_pkg::STS_BAD_PARAM;
			end else if (raw_idx == '0 || raw_idx >= IDX_LIMIT) begin
				pre_err  = 1'b1;
				pre_code = htfl_pkg::STS_BAD_HANDLE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_s1       <= opcode;
			obj_s1      <= object_ref;
			acc_s1      <= access_mask;
			addr_s1     <= rd_addr;
			err_s1      <= pre_err;
			err_code_s1 <= pre_code;
		end
	end

	// slot check, free list update and write-back data
	always_comb begin
		in_fill   = {1'b0, addr_s1} < fill_q;
		obj_cur   = in_fill ? ent_rd_s1[htfl_pkg::OBJ_W-1:0] : '0;
		if (in_fill) begin
			nxt_cur = nxt_rd_s1;
		end else if (addr_s1 == LAST_IDX) begin
			nxt_cur = '0;
		end else begin
			nxt_cur = addr_s1 + IDX_W'(1);
		end
		ok         = 1'b0;
		res_status = err_code_s1;
		if (!err_s1) begin
			if (op_s1 == htfl_pkg::OP_CREATE) begin
				ok = 1'b1;
			end else if (obj_cur != '0) begin
				ok = 1'b1;
			end else begin
				res_status = htfl_pkg::STS_BAD_HANDLE;
			end
		end
		ent_we    = exec_go && ok;
		nxt_we    = exec_go && ok && (op_s1 == htfl_pkg::OP_DESTROY);
		ent_wdata = (op_s1 == htfl_pkg::OP_CREATE) ? {acc_s1, obj_s1} : '0;
	end

	// entry memory: object and access rights
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[addr_s1] <= ent_wdata;
		end
		if (req_fire) begin
			ent_rd_s1 <= ent_mem[rd_addr];
		end
	end

	// next-free link memory
	always_ff @(posedge clk) begin
		if (nxt_we) begin
			nxt_mem[addr_s1] <= head_q;
		end
		if (req_fire) begin
			nxt_rd_s1 <= nxt_mem[rd_addr];
		end
	end

	// free head, fill mark and live count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= IDX_W'(1);
			fill_q <= (IDX_W+1)'(1);
			live_q <= '0;
		end else if (exec_go && ok) begin
			if (op_s1 == htfl_pkg::OP_CREATE) begin
				head_q <= nxt_cur;
				if ({1'b0, addr_s1} == fill_q) begin
					fill_q <= fill_q + (IDX_W+1)'(1);
				end
				live_q <= live_q + htfl_pkg::LIVE_W'(1);
			end else begin
				head_q <= addr_s1;
				live_q <= live_q - htfl_pkg::LIVE_W'(1);
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			status_q   <= res_status;
			handle_q   <= (ok && op_s1 == htfl_pkg::OP_CREATE) ?
				htfl_pkg::HND_W'({addr_s1, 2'b00}) : '0;
			released_q <= (ok && op_s1 == htfl_pkg::OP_DESTROY) ? obj_cur : '0;
			if (!ok) begin
				live_out_q <= live_q;
			end else if (op_s1 == htfl_pkg::OP_CREATE) begin
				live_out_q <= live_q + htfl_pkg::LIVE_W'(1);
			end else begin
				live_out_q <= live_q - htfl_pkg::LIVE_W'(1);
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign handle_out   = handle_q;
	assign released_ref = released_q;
	assign live_count   = live_out_q;

	// checks
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q == htfl_pkg::ST_EXEC)
		else $error("accepted request did not move to execute");

	a_exec_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |=> rsp_valid)
		else $error("finished request left no response beat");

	a_write_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ent_we |-> state_q == htfl_pkg::ST_EXEC && !err_s1)
		else $error("table write outside a checked request");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (IDX_W+1)'(TABLE_ENTRIES) && fill_q != '0)
		else $error("fill mark out of range");

endmodule

`default_nettype wire
